// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by the channel interfaces, the slot cell and the top level.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DATA_W = 32;
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operation carried by one request beat
    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_UPDATE  = 2'd2,
        KIND_EXTRACT = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ADD
    } state_t;

    // What every slot cell does on a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_DEL
    } cell_op_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        cell_op_t op;
        logic     from_neighbor; // add: take left entry, delete: take right entry
        logic     load_new;      // add: take broadcast entry
    } cell_ctl_t;

endpackage

// File: design/spq_in_if.sv
// Request channel of the sorted priority queue: valid/ready plus payload.
// Depends on spq_pkg for the field types.
`timescale 1ns / 1ps

interface spq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            kind;
    logic signed [spq_pkg::DATA_W-1:0]     entry_key;
    logic signed [spq_pkg::DATA_W-1:0]     entry_value;

    modport source (output valid, kind, entry_key, entry_value, input ready);
    modport sink   (input valid, kind, entry_key, entry_value, output ready);
endinterface

// File: design/spq_out_if.sv
// Result channel of the sorted priority queue: valid/ready plus payload.
// Depends on spq_pkg for the field types.
`timescale 1ns / 1ps

interface spq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [spq_pkg::DATA_W-1:0]     out_value;
    logic                                  hit;
    logic                                  dropped;
    logic                                  is_empty;
    logic                                  is_full;

    modport source (output valid, out_value, hit, dropped, is_empty, is_full, input ready);
    modport sink   (input valid, out_value, hit, dropped, is_empty, is_full, output ready);
endinterface

// File: design/spq_cell.sv
// One slot of the sorted array: holds a (key, value) entry and shifts it
// to or from its neighbors. Depends on spq_pkg for the control struct.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              clk,
    input  spq_pkg::cell_ctl_t                ctl,
    input  logic signed [spq_pkg::DATA_W-1:0] new_key,
    input  logic signed [spq_pkg::DATA_W-1:0] new_value,
    input  logic signed [spq_pkg::DATA_W-1:0] left_key,
    input  logic signed [spq_pkg::DATA_W-1:0] left_value,
    input  logic signed [spq_pkg::DATA_W-1:0] right_key,
    input  logic signed [spq_pkg::DATA_W-1:0] right_value,
    input  logic                              occupied,
    output logic signed [spq_pkg::DATA_W-1:0] key,
    output logic signed [spq_pkg::DATA_W-1:0] value,
    output logic                              not_below,
    output logic                              above,
    output logic                              match
);

    logic signed [spq_pkg::DATA_W-1:0] key_reg, key_next;
    logic signed [spq_pkg::DATA_W-1:0] value_reg, value_next;

    // Compare against the broadcast entry
    assign not_below = !occupied || !(key_reg < new_key);
    assign above     = occupied && (new_key < key_reg);
    assign match     = occupied && (value_reg == new_value);
    assign key       = key_reg;
    assign value     = value_reg;

    // Next entry: keep, shift from a neighbor or load the new one
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (ctl.op)
            spq_pkg::CELL_ADD:
            begin
                if (ctl.from_neighbor)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
                else if (ctl.load_new)
                begin
                    key_next   = new_key;
                    value_next = new_value;
                end
            end
            spq_pkg::CELL_DEL:
            begin
                if (ctl.from_neighbor)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// File: design/sorted_priority_queue_top.sv
// A result beat is registered from S_EXEC after its request is accepted, from S_ADD
// for update; that state waits while an earlier result beat is still offered. The
// request port is ready only in S_IDLE; the slot row does at most one shift per cycle.
// A waiting result does not block the next request until that request completes.
// Reset (rst_n, async low) empties the queue and clears the sequencer and the
// result valid flag; slot contents and result payload stay undefined until written.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spq_in_if.sink      request,
    spq_out_if.source   result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    spq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    spq_pkg::kind_t   kind_reg;
    logic signed [spq_pkg::DATA_W-1:0] key_reg, value_reg;
    logic hit_reg, hit_next;

    logic                               out_valid_reg, out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0]  out_value_reg, out_value_next;
    logic out_hit_reg, out_hit_next;
    logic out_dropped_reg, out_dropped_next;
    logic out_empty_reg, out_empty_next;
    logic out_full_reg, out_full_next;

    logic signed [spq_pkg::DATA_W-1:0] cell_key   [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] occupied, not_below, above, match_vec;
    logic [CAPACITY-1:0] ins_at, prior_match;
    spq_pkg::cell_ctl_t  cell_ctl [CAPACITY];

    spq_pkg::cell_op_t   row_op;
    logic                shift_all;
    logic                out_free;
    logic                any_match;

    assign request.ready   = (state_reg == spq_pkg::S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.out_value = out_value_reg;
    assign result.hit      = out_hit_reg;
    assign result.dropped  = out_dropped_reg;
    assign result.is_empty = out_empty_reg;
    assign result.is_full  = out_full_reg;

    assign out_free  = !out_valid_reg || result.ready;
    assign any_match = |match_vec;

    // Slot row with per-cell insert and first-match flags
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occupied[i] = (count_reg > CNT_W'(i));

        // insertion point is at or before slot i
        if (i == 0)
        begin : g_head
            assign ins_at[i]      = !occupied[i] || above[i];
            assign prior_match[i] = 1'b0;
            assign cell_ctl[i].from_neighbor = (row_op == spq_pkg::CELL_DEL) &&
                                               (shift_all || match_vec[i]);
        end
        else
        begin : g_body
            assign ins_at[i]      = not_below[i];
            assign prior_match[i] = |match_vec[i-1:0];
            assign cell_ctl[i].from_neighbor = (row_op == spq_pkg::CELL_DEL) ?
                (shift_all || prior_match[i] || match_vec[i]) : ins_at[i-1];
        end

        assign cell_ctl[i].op       = row_op;
        assign cell_ctl[i].load_new = ins_at[i];

        spq_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .new_key    (key_reg),
            .new_value  (value_reg),
            .left_key   (cell_key[(i == 0) ? 0 : i-1]),
            .left_value (cell_value[(i == 0) ? 0 : i-1]),
            .right_key  (cell_key[(i == CAPACITY-1) ? i : i+1]),
            .right_value(cell_value[(i == CAPACITY-1) ? i : i+1]),
            .occupied   (occupied[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .not_below  (not_below[i]),
            .above      (above[i]),
            .match      (match_vec[i])
        );
    end

    // Sequencer: next state, row command and result
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        row_op           = spq_pkg::CELL_HOLD;
        shift_all        = 1'b0;
        out_valid_next   = out_valid_reg && !result.ready;
        out_value_next   = out_value_reg;
        out_hit_next     = out_hit_reg;
        out_dropped_next = out_dropped_reg;
        out_empty_next   = out_empty_reg;
        out_full_next    = out_full_reg;

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (request.valid)
                    state_next = spq_pkg::S_EXEC;
            end
            spq_pkg::S_EXEC:
            begin
                if (kind_reg == spq_pkg::KIND_UPDATE)
                begin
                    // remove half of update; result comes after the add
                    hit_next = any_match;
                    if (any_match)
                    begin
                        row_op     = spq_pkg::CELL_DEL;
                        count_next = count_reg - 1'b1;
                    end
                    state_next = spq_pkg::S_ADD;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = '0;
                    out_hit_next     = 1'b0;
                    out_dropped_next = 1'b0;
                    case (kind_reg)
                        spq_pkg::KIND_ADD:
                        begin
                            if (count_reg != CNT_FULL)
                            begin
                                row_op     = spq_pkg::CELL_ADD;
                                count_next = count_reg + 1'b1;
                            end
                            else
                                out_dropped_next = 1'b1;
                        end
                        spq_pkg::KIND_REMOVE:
                        begin
                            out_hit_next = any_match;
                            if (any_match)
                            begin
                                row_op     = spq_pkg::CELL_DEL;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // extract minimum: pop the head
                            if (count_reg != '0)
                            begin
                                row_op         = spq_pkg::CELL_DEL;
                                shift_all      = 1'b1;
                                count_next     = count_reg - 1'b1;
                                out_value_next = cell_value[0];
                                out_hit_next   = 1'b1;
                            end
                            else
                                out_value_next = spq_pkg::INT_MIN;
                        end
                    endcase
                    out_empty_next = (count_next == '0);
                    out_full_next  = (count_next == CNT_FULL);
                    state_next     = spq_pkg::S_IDLE;
                end
            end
            spq_pkg::S_ADD:
            begin
                // add half of update
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = '0;
                    out_hit_next     = hit_reg;
                    out_dropped_next = 1'b0;
                    if (count_reg != CNT_FULL)
                    begin
                        row_op     = spq_pkg::CELL_ADD;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        out_dropped_next = 1'b1;
                    out_empty_next = (count_next == '0);
                    out_full_next  = (count_next == CNT_FULL);
                    state_next     = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured request and result payload
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            kind_reg  <= spq_pkg::kind_t'(request.kind);
            key_reg   <= request.entry_key;
            value_reg <= request.entry_value;
        end
        hit_reg         <= hit_next;
        out_value_reg   <= out_value_next;
        out_hit_reg     <= out_hit_next;
        out_dropped_reg <= out_dropped_next;
        out_empty_reg   <= out_empty_next;
        out_full_reg    <= out_full_next;
    end

endmodule

// File: design/spq_checker.sv
// Port-level checks for sorted_priority_queue_top, attached with bind.
// Depends on the top level's request and result channel ports.
`timescale 1ns / 1ps

module spq_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_hit,
    input logic rsp_dropped,
    input logic rsp_empty,
    input logic rsp_full
);

    // a result beat stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat withdrawn before it was taken");

    // one request at a time: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is in progress");

    // a drop only happens on a full queue with nothing removed
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_dropped |-> rsp_full && !rsp_hit)
        else $error("dropped add reported without a full queue");

    // queue cannot be empty and full at once
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_empty && rsp_full))
        else $error("result flags report empty and full together");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (result.valid),
    .rsp_ready  (result.ready),
    .rsp_hit    (result.hit),
    .rsp_dropped(result.dropped),
    .rsp_empty  (result.is_empty),
    .rsp_full   (result.is_full)
);

// File: test/tb_sorted_priority_queue_top.sv
// Self-checking testbench for sorted_priority_queue_top: directed and random traffic
// with a built-in model of the sorted queue. Depends on spq_pkg, spq_in_if, spq_out_if.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;

    localparam int CAPACITY = 16;
    localparam logic signed [spq_pkg::DATA_W-1:0] KEY_MAX =
        {1'b0, {(spq_pkg::DATA_W-1){1'b1}}};

    // One result beat as the queue should produce it
    typedef struct packed {
        logic signed [spq_pkg::DATA_W-1:0] out_value;
        logic                              hit;
        logic                              dropped;
        logic                              is_empty;
        logic                              is_full;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_in_if  req_if ();
    spq_out_if res_if ();

    sorted_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_if),
        .result (res_if)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the queue contents, head at slot 0
    logic signed [spq_pkg::DATA_W-1:0] model_keys   [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] model_values [CAPACITY];
    int                                model_count = 0;

    queue_result_t expected_results [$];
    int            error_count   = 0;
    int            send_idle_pct = 9;
    int            recv_idle_pct = 70;

    // Close the gap left by the entry at pos
    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < model_count; i++)
        begin
            model_keys[i]   = model_keys[i + 1];
            model_values[i] = model_values[i + 1];
        end
        model_count--;
    endfunction

    // Sorted insert; an equal key never goes ahead of the head. Returns 1 if full.
    function automatic logic insert_entry(logic signed [spq_pkg::DATA_W-1:0] key,
                                          logic signed [spq_pkg::DATA_W-1:0] value);
        int pos;
        if (model_count >= CAPACITY)
            return 1'b1;
        if (model_count == 0 || key < model_keys[0])
            pos = 0;
        else
        begin
            pos = 1;
            while (pos < model_count && model_keys[pos] < key)
                pos++;
        end
        for (int i = model_count; i > pos; i--)
        begin
            model_keys[i]   = model_keys[i - 1];
            model_values[i] = model_values[i - 1];
        end
        model_keys[pos]   = key;
        model_values[pos] = value;
        model_count++;
        return 1'b0;
    endfunction

    // Delete the first entry from the head holding value. Returns 1 on a match.
    function automatic logic remove_value(logic signed [spq_pkg::DATA_W-1:0] value);
        for (int i = 0; i < model_count; i++)
        begin
            if (model_values[i] == value)
            begin
                drop_slot(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one operation to the shadow queue and return the result it should give
    function automatic queue_result_t step_queue(spq_pkg::kind_t op,
                                                 logic signed [spq_pkg::DATA_W-1:0] key,
                                                 logic signed [spq_pkg::DATA_W-1:0] value);
        queue_result_t r;
        r = '0;
        case (op)
            spq_pkg::KIND_ADD:
                r.dropped = insert_entry(key, value);
            spq_pkg::KIND_REMOVE:
                r.hit = remove_value(value);
            spq_pkg::KIND_UPDATE:
            begin
                r.hit     = remove_value(value);
                r.dropped = insert_entry(key, value);
            end
            default:
            begin
                if (model_count == 0)
                    r.out_value = spq_pkg::INT_MIN;
                else
                begin
                    r.out_value = model_values[0];
                    drop_slot(0);
                    r.hit = 1'b1;
                end
            end
        endcase
        r.is_empty = (model_count == 0);
        r.is_full  = (model_count >= CAPACITY);
        return r;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Drive one request beat; valid stays high after acceptance unless a gap follows
    task automatic send_op(spq_pkg::kind_t op, logic signed [spq_pkg::DATA_W-1:0] key,
                           logic signed [spq_pkg::DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= op;
        req_if.entry_key   <= key;
        req_if.entry_value <= value;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        expected_results.push_back(step_queue(op, key, value));
    endtask

    function automatic logic signed [spq_pkg::DATA_W-1:0] rand_key();
        case ($urandom_range(0, 15))
            0:       return spq_pkg::INT_MIN;
            1:       return KEY_MAX;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 12)) - 6;
        endcase
    endfunction

    // Mostly a small pool so removes and updates find matches
    function automatic logic signed [spq_pkg::DATA_W-1:0] rand_value();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 19);
    endfunction

    // Empty queue: extract, remove, and update acting as a plain add
    task automatic test_empty_queue();
        send_op(spq_pkg::KIND_EXTRACT, 0, 0);
        send_op(spq_pkg::KIND_REMOVE, 0, -1);
        send_op(spq_pkg::KIND_UPDATE, 3, 7);
        send_op(spq_pkg::KIND_EXTRACT, -1, -1);
    endtask

    // Placement rules, extreme keys, duplicate values, update moving an entry
    task automatic test_ordering();
        send_op(spq_pkg::KIND_ADD, 0, 7);
        send_op(spq_pkg::KIND_ADD, 0, 8);                          // ties with the head
        send_op(spq_pkg::KIND_ADD, spq_pkg::INT_MIN, KEY_MAX);     // new head
        send_op(spq_pkg::KIND_ADD, KEY_MAX, spq_pkg::INT_MIN);     // tail
        send_op(spq_pkg::KIND_ADD, -1, 8);                         // second value 8
        send_op(spq_pkg::KIND_REMOVE, 0, 8);                       // nearer the head goes
        send_op(spq_pkg::KIND_UPDATE, KEY_MAX, 7);                 // ahead of equal tail
    endtask

    // Fill to capacity, then drops and updates on a full queue
    task automatic test_full_queue();
        while (model_count < CAPACITY)
            send_op(spq_pkg::KIND_ADD, rand_key(), $urandom);
        send_op(spq_pkg::KIND_ADD, -5, 99);
        send_op(spq_pkg::KIND_UPDATE, 2, 32'sd123456);  // no match: dropped add
        send_op(spq_pkg::KIND_UPDATE, -7, 7);           // match: stays full
        send_op(spq_pkg::KIND_EXTRACT, 0, 0);
    endtask

    // Random traffic alternating between filling and draining the queue
    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        logic           filling;
        int             roll;
        spq_pkg::kind_t op;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        filling = 1'b1;
        for (int n = 0; n < n_items; n++)
        begin
            if (model_count == 0)
                filling = 1'b1;
            else if (model_count == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (filling)
                op = (roll < 45) ? spq_pkg::KIND_ADD : (roll < 55) ? spq_pkg::KIND_REMOVE :
                     (roll < 75) ? spq_pkg::KIND_UPDATE : spq_pkg::KIND_EXTRACT;
            else
                op = (roll < 20) ? spq_pkg::KIND_ADD : (roll < 40) ? spq_pkg::KIND_REMOVE :
                     (roll < 50) ? spq_pkg::KIND_UPDATE : spq_pkg::KIND_EXTRACT;
            send_op(op, rand_key(), rand_value());
        end
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_error("result beat with no request pending");
            else
            begin
                want = expected_results.pop_front();
                if (res_if.out_value !== want.out_value)
                    report_error($sformatf("out_value: expected %h, got %h",
                                           want.out_value, res_if.out_value));
                if (res_if.hit !== want.hit)
                    report_error($sformatf("hit: expected %b, got %b",
                                           want.hit, res_if.hit));
                if (res_if.dropped !== want.dropped)
                    report_error($sformatf("dropped: expected %b, got %b",
                                           want.dropped, res_if.dropped));
                if (res_if.is_empty !== want.is_empty)
                    report_error($sformatf("is_empty: expected %b, got %b",
                                           want.is_empty, res_if.is_empty));
                if (res_if.is_full !== want.is_full)
                    report_error($sformatf("is_full: expected %b, got %b",
                                           want.is_full, res_if.is_full));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.kind        <= spq_pkg::KIND_ADD;
        req_if.entry_key   <= '0;
        req_if.entry_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_ordering();
        test_full_queue();
        test_random_traffic(600, 9, 70);
        test_random_traffic(600, 70, 9);
        test_random_traffic(600, 0, 0);

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard
    initial
    begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
